[rtl/min_paint_strokes_interval_dp_core_assert.svh]
// Assertion macros shared by the paint-stroke interval solver.
`ifndef MIN_PAINT_STROKES_INTERVAL_DP_CORE_ASSERT_SVH
`define MIN_PAINT_STROKES_INTERVAL_DP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mps_pkg.sv]
// Shared constants and beat types of the paint-stroke interval solver.
package mps_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int STROKES_MAX = 127;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] strokes;
        logic       overflow;
    } t_out_beat;

endpackage

[rtl/min_paint_strokes_interval_dp_core.sv]
// Top level of the paint-stroke interval solver: symbol memory, cost table and sequencer.
// Symbols stream in one beat per cycle while the core is idle and are written to a symbol
// memory. The beat marked last starts an interval solve over the stored string of n symbols,
// during which the input is stalled. The solve walks the cost table from the last left end
// back to the first, each row from short intervals to long ones, with one read-modify-write
// sequencer: a diagonal entry is written directly, an interval whose end symbols match
// compares them and takes the cheaper of the two shorter intervals, and any other interval
// steps through its split points, as the two table read ports deliver one split point per
// cycle. The result then goes to the output register once any earlier result stalled there
// is taken. The output register lets the next string start loading while the result waits.
module min_paint_strokes_interval_dp_core #(
    parameter int MAX_LEN = mps_pkg::MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mps_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output mps_pkg::t_out_beat o_data
);
    import mps_pkg::*;

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = LW;
    localparam int TD = MAX_LEN * MAX_LEN;
    localparam int AW = (TD > 1) ? $clog2(TD) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIAG = 6'b000010,
        S_SYM  = 6'b000100,
        S_CMP  = 6'b001000,
        S_RUN  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    function automatic logic [AW-1:0] cost_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
        cost_addr = AW'(int'(a) * MAX_LEN + int'(b));
    endfunction

    // Control state
    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic            r_ovf, n_ovf;
    logic            r_out_valid, n_out_valid;
    // Sequencer payload
    logic [IW-1:0]   r_l, n_l;
    logic [IW-1:0]   r_r, n_r;
    logic [IW-1:0]   r_m, n_m;
    logic            r_more, n_more;
    logic            r_eq, n_eq;
    logic [CW:0]     r_best, n_best;
    logic [CW-1:0]   r_res, n_res;
    t_out_beat       r_out, n_out;

    // Memories and their ports
    logic [7:0]      r_sym_mem [MAX_LEN];
    logic [CW-1:0]   r_cost_mem [TD];
    logic [7:0]      r_sym_a, r_sym_b;
    logic [CW-1:0]   r_cost_a, r_cost_b;

    logic            sym_we, sym_re, cost_we, cost_re;
    logic [IW-1:0]   sym_wa;
    logic [AW-1:0]   cost_wa, cost_ra, cost_rb;
    logic [CW-1:0]   cost_wd;

    logic            full;
    logic            l_next_in;
    logic            r_next_in;
    logic [CW:0]     step_val;
    logic [CW:0]     best_now;
    logic            sat;

    assign full      = (r_len >= LW'(MAX_LEN));
    assign l_next_in = (((LW + 1)'(r_l) + (LW + 1)'(1)) < (LW + 1)'(r_len));
    assign r_next_in = (((LW + 1)'(r_r) + (LW + 1)'(1)) < (LW + 1)'(r_len));

    // A matching pair takes the cheaper of the two shorter intervals; otherwise it is a split.
    always_comb begin
        if (r_eq) begin
            step_val = (r_cost_a < r_cost_b) ? (CW + 1)'(r_cost_a) : (CW + 1)'(r_cost_b);
        end else begin
            step_val = (CW + 1)'(r_cost_a) + (CW + 1)'(r_cost_b);
        end
        best_now = (step_val < r_best) ? step_val : r_best;
    end

    assign sat = (32'(r_res) > 32'(STROKES_MAX));

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_l         = r_l;
        n_r         = r_r;
        n_m         = r_m;
        n_more      = r_more;
        n_eq        = r_eq;
        n_best      = r_best;
        n_res       = r_res;
        n_out       = r_out;
        sym_we      = 1'b0;
        sym_wa      = IW'(r_len);
        sym_re      = 1'b0;
        cost_we     = 1'b0;
        cost_wa     = cost_addr(r_l, r_r);
        cost_wd     = CW'(best_now);
        cost_re     = 1'b0;
        cost_ra     = cost_addr(r_l, r_m);
        cost_rb     = cost_addr(IW'(r_m + IW'(1)), r_r);
        o_stall     = (r_state != S_IDLE);

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!full) begin
                        sym_we = 1'b1;
                        n_len  = r_len + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_data.last) begin
                        n_l     = full ? IW'(MAX_LEN - 1) : IW'(r_len);
                        n_state = S_DIAG;
                    end
                end
            end
            S_DIAG: begin
                cost_we = 1'b1;
                cost_wa = cost_addr(r_l, r_l);
                cost_wd = CW'(1);
                if (l_next_in) begin
                    n_r     = r_l + IW'(1);
                    n_state = S_SYM;
                end else if (r_l == '0) begin
                    n_res   = CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_l = r_l - IW'(1);
                end
            end
            S_SYM: begin
                sym_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                cost_re = 1'b1;
                n_best  = '1;
                n_state = S_RUN;
                if (r_sym_a == r_sym_b) begin
                    cost_ra = cost_addr(r_l + IW'(1), r_r);
                    cost_rb = cost_addr(r_l, r_r - IW'(1));
                    n_eq    = 1'b1;
                    n_more  = 1'b0;
                end else begin
                    cost_ra = cost_addr(r_l, r_l);
                    cost_rb = cost_addr(r_l + IW'(1), r_r);
                    n_eq    = 1'b0;
                    n_m     = r_l + IW'(1);
                    n_more  = ((r_l + IW'(1)) != r_r);
                end
            end
            S_RUN: begin
                n_best = best_now;
                if (r_more) begin
                    cost_re = 1'b1;
                    n_m     = r_m + IW'(1);
                    n_more  = ((r_m + IW'(1)) != r_r);
                end else begin
                    cost_we = 1'b1;
                    if (r_next_in) begin
                        n_r     = r_r + IW'(1);
                        n_state = S_SYM;
                    end else if (r_l == '0) begin
                        n_res   = CW'(best_now);
                        n_state = S_DONE;
                    end else begin
                        n_l     = r_l - IW'(1);
                        n_state = S_DIAG;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.strokes  = sat ? 7'(STROKES_MAX) : 7'(r_res);
                    n_out.overflow = r_ovf;
                    n_out_valid    = 1'b1;
                    n_len          = '0;
                    n_ovf          = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l    <= n_l;
        r_r    <= n_r;
        r_m    <= n_m;
        r_more <= n_more;
        r_eq   <= n_eq;
        r_best <= n_best;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // Symbol memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            r_sym_mem[sym_wa] <= i_data.symbol;
        end
        if (sym_re) begin
            r_sym_a <= r_sym_mem[r_l];
            r_sym_b <= r_sym_mem[r_r];
        end
    end

    // Cost table: one write port, two registered read ports.
    // Every read of an entry is issued after its write has landed in the table, so no forwarding.
    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            r_cost_mem[cost_wa] <= cost_wd;
        end
        if (cost_re) begin
            r_cost_a <= r_cost_mem[cost_ra];
            r_cost_b <= r_cost_mem[cost_rb];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`include "min_paint_strokes_interval_dp_core_assert.svh"

    `MPS_ASSERT_NEXT(a_last_starts_solve, i_valid && !o_stall && i_data.last, r_state == S_DIAG, "solve did not start after last beat")
    `MPS_ASSERT_NOW(a_len_bounded, 1'b1, r_len <= LW'(MAX_LEN), "symbol count beyond maximum length")
    `MPS_ASSERT_NOW(a_split_in_range, r_state == S_RUN && r_more, (r_m > r_l) && (r_m < r_r), "split point outside interval")
    `MPS_ASSERT_NOW(a_solve_has_string, r_state == S_DIAG, (LW + 1)'(r_l) < (LW + 1)'(r_len), "solve row beyond stored string")
    `MPS_ASSERT_NOW(a_result_nonzero, $rose(o_valid), o_data.strokes != 7'd0, "zero stroke count delivered")

endmodule
